### rtl/itcl_pkg.sv
// Shared types, codes and default sizes for the interval tract class lookup.
package itcl_pkg;

  localparam int unsigned MAX_TRACTS_DEF   = 1024;
  localparam int unsigned MAX_EXCLUDED_DEF = 16;
  localparam int unsigned NUM_CLASSES_DEF  = 16;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned CLS_W     = 4;
  localparam int unsigned CFG_IDX_W = 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CLS_W-1:0] cls_t;

  typedef enum logic [1:0] {
    FUNC_LOAD_TRACT = 2'd0,
    FUNC_LOAD_SKIP  = 2'd1,
    FUNC_QUERY      = 2'd2,
    FUNC_CLEAR      = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    BKT_TRACT      = 3'd0,
    BKT_NONE       = 3'd1,
    BKT_UNASSESSED = 3'd2,
    BKT_INELIGIBLE = 3'd3,
    BKT_LOADED     = 3'd4,
    BKT_FULL       = 3'd5
  } bucket_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LOW   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_HIGH  = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_FINAL
  } state_e;

  typedef struct packed {
    pos_t first;
    pos_t last;
    cls_t kind;
  } tract_t;

  typedef struct packed {
    pos_t first;
    pos_t last;
  } skip_t;

endpackage

### rtl/itcl_if.sv
// Handshake channel interfaces: request items, result items and register writes.
interface itcl_req_if
  import itcl_pkg::*;
();
  logic  valid;
  logic  ready;
  func_e func;
  pos_t  first_pos;
  pos_t  last_pos;
  cls_t  load_class;
  logic  chr_assessed;
  logic  eligible;

  modport source (output valid, func, first_pos, last_pos, load_class, chr_assessed,
                  eligible, input ready);
  modport sink   (input valid, func, first_pos, last_pos, load_class, chr_assessed,
                  eligible, output ready);
endinterface

interface itcl_rsp_if
  import itcl_pkg::*;
();
  logic    valid;
  logic    ready;
  bucket_e bucket;
  cls_t    size_class;

  modport source (output valid, bucket, size_class, input ready);
  modport sink   (input valid, bucket, size_class, output ready);
endinterface

interface itcl_cfg_if
  import itcl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  pos_t                 data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

### rtl/interval_tract_class_lookup_top.sv
// Top level: tract table, excluded list and the search sequencer for position lookups.
//
//  Channel  Dir  Payload                                              Accepted when
//  req_i    in   func, first_pos, last_pos, load_class, chr_assessed, valid && ready
//                eligible
//  rsp_o    out  bucket, size_class                                   valid && ready
//  cfg_i    in   idx, data                                            valid (ready is high)
//
// Loads and clears finish in the cycle they are accepted; the result is registered and shows in the next cycle.
// A query is settled by the checks in ST_CHECK, or else goes to ST_SEARCH, where the excluded-list
// scan and a binary search of at most ceil(log2(tract count + 1)) probes run side by side; a
// candidate tract, if there is one, is then compared in ST_FINAL.
// Reset empties both tables by clearing their counts; no clearing pass is needed.
// A result waits in the output register; the next item is taken in ST_IDLE once it is empty or taken.
module interval_tract_class_lookup_top
  import itcl_pkg::*;
#(
  parameter int unsigned MAX_TRACTS   = MAX_TRACTS_DEF,
  parameter int unsigned MAX_EXCLUDED = MAX_EXCLUDED_DEF,
  parameter int unsigned NUM_CLASSES  = NUM_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itcl_req_if.sink    req_i,
  itcl_rsp_if.source  rsp_o,
  itcl_cfg_if.sink    cfg_i
);

  localparam int unsigned CNT_W    = $clog2(MAX_TRACTS + 1);
  localparam int unsigned IDX_W    = (MAX_TRACTS > 1) ? $clog2(MAX_TRACTS) : 1;
  localparam int unsigned SK_DEPTH = (MAX_EXCLUDED > 0) ? MAX_EXCLUDED : 1;
  localparam int unsigned SK_CNT_W = (MAX_EXCLUDED > 0) ? $clog2(MAX_EXCLUDED + 1) : 1;
  localparam int unsigned SK_IDX_W = (SK_DEPTH > 1) ? $clog2(SK_DEPTH) : 1;

  localparam logic [CNT_W-1:0]    TR_FULL = CNT_W'(MAX_TRACTS);
  localparam logic [SK_CNT_W-1:0] SK_FULL = SK_CNT_W'(MAX_EXCLUDED);
  localparam logic [8:0]          NCLS    = 9'(NUM_CLASSES);
  localparam cls_t                CLS_TOP = CLS_W'(NUM_CLASSES - 1);

  // Storage
  tract_t tr_mem [MAX_TRACTS];
  skip_t  sk_mem [SK_DEPTH];

  state_e state_q, state_d;
  pos_t   span_lo_q, span_hi_q, gap_lo_q, gap_hi_q;
  logic [CNT_W-1:0]    tr_cnt_q, tr_cnt_d;
  logic [SK_CNT_W-1:0] sk_cnt_q, sk_cnt_d;
  pos_t   pos_q, pos_d;
  logic   assessed_q, assessed_d;
  logic   elig_q, elig_d;
  logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  logic   bs_cmp_q, bs_cmp_d;
  logic [SK_CNT_W-1:0] k_q, k_d;
  logic   sk_vld_q, sk_vld_d;
  logic   out_valid_q, out_valid_d;
  bucket_e out_bkt_q, out_bkt_d;
  cls_t   out_cls_q, out_cls_d;
  tract_t tr_rd_q;
  skip_t  sk_rd_q;

  logic             in_acc;
  logic             tr_we, sk_we;
  logic [IDX_W-1:0] tr_ra;
  logic [CNT_W:0]   bs_sum;
  logic [IDX_W-1:0] mid_new;
  logic [CNT_W-1:0] lo_m1;
  logic             bs_done, sk_done, sk_hit, sk_rd_en;
  cls_t             cls_in;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign in_acc      = req_i.valid && req_i.ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.bucket     = out_bkt_q;
  assign rsp_o.size_class = out_cls_q;

  assign cls_in  = (9'(req_i.load_class) >= NCLS) ? CLS_TOP : req_i.load_class;
  assign bs_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_new = bs_sum[IDX_W:1];
  assign lo_m1   = lo_q - CNT_W'(1);
  assign bs_done = (lo_q >= hi_q) && !bs_cmp_q;
  assign sk_done = (k_q >= sk_cnt_q) && !sk_vld_q;
  assign sk_hit  = sk_vld_q && (pos_q >= sk_rd_q.first) && (pos_q <= sk_rd_q.last);
  assign sk_rd_en = (state_q == ST_SEARCH) && (k_q < sk_cnt_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_lo_q <= '0;
      span_hi_q <= '1;
      gap_lo_q  <= '0;
      gap_hi_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        CFG_SPAN_LOW:  span_lo_q <= cfg_i.data;
        CFG_SPAN_HIGH: span_hi_q <= cfg_i.data;
        CFG_GAP_LOW:   gap_lo_q  <= cfg_i.data;
        CFG_GAP_HIGH:  gap_hi_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Tract and excluded-interval memories, read data registered every cycle.
  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      tr_mem[tr_cnt_q[IDX_W-1:0]] <= '{first: req_i.first_pos, last: req_i.last_pos,
                                      kind: cls_in};
    end
    tr_rd_q <= tr_mem[tr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) begin
      sk_mem[sk_cnt_q[SK_IDX_W-1:0]] <= '{first: req_i.first_pos, last: req_i.last_pos};
    end
    sk_rd_q <= sk_mem[k_q[SK_IDX_W-1:0]];
  end

  // Control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tr_cnt_q    <= '0;
      sk_cnt_q    <= '0;
      bs_cmp_q    <= 1'b0;
      sk_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tr_cnt_q    <= tr_cnt_d;
      sk_cnt_q    <= sk_cnt_d;
      bs_cmp_q    <= bs_cmp_d;
      sk_vld_q    <= sk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    assessed_q <= assessed_d;
    elig_q     <= elig_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    k_q        <= k_d;
    out_bkt_q  <= out_bkt_d;
    out_cls_q  <= out_cls_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    tr_cnt_d    = tr_cnt_q;
    sk_cnt_d    = sk_cnt_q;
    pos_d       = pos_q;
    assessed_d  = assessed_q;
    elig_d      = elig_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    bs_cmp_d    = bs_cmp_q;
    k_d         = k_q;
    sk_vld_d    = sk_rd_en;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_bkt_d   = out_bkt_q;
    out_cls_d   = out_cls_q;
    tr_we       = 1'b0;
    sk_we       = 1'b0;
    tr_ra       = lo_m1[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_cls_d = '0;
          unique case (req_i.func)
            FUNC_LOAD_TRACT: begin
              out_valid_d = 1'b1;
              if (tr_cnt_q < TR_FULL) begin
                tr_we     = 1'b1;
                tr_cnt_d  = tr_cnt_q + CNT_W'(1);
                out_bkt_d = BKT_LOADED;
              end else begin
                out_bkt_d = BKT_FULL;
              end
            end
            FUNC_LOAD_SKIP: begin
              out_valid_d = 1'b1;
              if (sk_cnt_q < SK_FULL) begin
                sk_we     = 1'b1;
                sk_cnt_d  = sk_cnt_q + SK_CNT_W'(1);
                out_bkt_d = BKT_LOADED;
              end else begin
                out_bkt_d = BKT_FULL;
              end
            end
            FUNC_QUERY: begin
              pos_d      = req_i.first_pos;
              assessed_d = req_i.chr_assessed;
              elig_d     = req_i.eligible;
              state_d    = ST_CHECK;
            end
            FUNC_CLEAR: begin
              tr_cnt_d    = '0;
              sk_cnt_d    = '0;
              out_valid_d = 1'b1;
              out_bkt_d   = BKT_LOADED;
            end
          endcase
        end
      end

      ST_CHECK: begin
        if (!assessed_q) begin
          out_valid_d = 1'b1;
          out_bkt_d   = BKT_UNASSESSED;
          state_d     = ST_IDLE;
        end else if (!elig_q) begin
          out_valid_d = 1'b1;
          out_bkt_d   = BKT_INELIGIBLE;
          state_d     = ST_IDLE;
        end else if ((pos_q < span_lo_q) || (pos_q > span_hi_q) ||
                     ((gap_hi_q > gap_lo_q) && (pos_q >= gap_lo_q) && (pos_q <= gap_hi_q))) begin
          out_valid_d = 1'b1;
          out_bkt_d   = BKT_UNASSESSED;
          state_d     = ST_IDLE;
        end else begin
          lo_d     = '0;
          hi_d     = tr_cnt_q;
          bs_cmp_d = 1'b0;
          k_d      = '0;
          state_d  = ST_SEARCH;
        end
      end

      // The excluded-list scan and the binary search run side by side.
      ST_SEARCH: begin
        if (sk_hit) begin
          out_valid_d = 1'b1;
          out_bkt_d   = BKT_UNASSESSED;
          state_d     = ST_IDLE;
        end else begin
          if (sk_rd_en) begin
            k_d = k_q + SK_CNT_W'(1);
          end
          if (!bs_cmp_q && (lo_q < hi_q)) begin
            mid_d    = mid_new;
            tr_ra    = mid_new;
            bs_cmp_d = 1'b1;
          end else if (bs_cmp_q) begin
            if (tr_rd_q.first <= pos_q) begin
              lo_d = CNT_W'(mid_q) + CNT_W'(1);
            end else begin
              hi_d = CNT_W'(mid_q);
            end
            bs_cmp_d = 1'b0;
          end
          // Once the search is done the read port keeps fetching the candidate entry.
          if (bs_done && sk_done) begin
            if (lo_q == '0) begin
              out_valid_d = 1'b1;
              out_bkt_d   = BKT_NONE;
              state_d     = ST_IDLE;
            end else begin
              state_d = ST_FINAL;
            end
          end
        end
      end

      ST_FINAL: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
        if (pos_q <= tr_rd_q.last) begin
          out_bkt_d = BKT_TRACT;
          out_cls_d = tr_rd_q.kind;
        end else begin
          out_bkt_d = BKT_NONE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Checks
  a_tract_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_cnt_q <= TR_FULL)
    else $error("tract count beyond capacity");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> lo_q <= hi_q)
    else $error("binary search bounds crossed");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_i.func != FUNC_QUERY) |=>
      out_valid_q && ((out_bkt_q == BKT_LOADED) || (out_bkt_q == BKT_FULL)))
    else $error("load or clear item gave no load result");

  a_class_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_bkt_q != BKT_TRACT) |-> out_cls_q == '0)
    else $error("size class set outside a tract result");

  a_final_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINAL |-> lo_q != '0)
    else $error("final compare without a candidate tract");

endmodule

### test/itcl_lookup_checker.sv
// Checker for the interval tract class lookup: mirrors the tables, predicts and compares results.
`timescale 1ns / 100ps
module itcl_lookup_checker
  import itcl_pkg::*;
#(
  parameter int unsigned MAX_TRACTS   = MAX_TRACTS_DEF,
  parameter int unsigned MAX_EXCLUDED = MAX_EXCLUDED_DEF,
  parameter int unsigned NUM_CLASSES  = NUM_CLASSES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itcl_req_if         req_i,
  itcl_rsp_if         rsp_i,
  itcl_cfg_if         cfg_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned hits_o
);

  typedef struct packed {
    bucket_e bucket;
    cls_t    size_class;
  } lookup_res_t;

  // Shadow copy of the registers and both tables.
  pos_t        span_lo, span_hi, gap_lo, gap_hi;
  pos_t        tr_first [MAX_TRACTS];
  pos_t        tr_last  [MAX_TRACTS];
  cls_t        tr_cls   [MAX_TRACTS];
  int unsigned tr_cnt;
  pos_t        ex_first [MAX_EXCLUDED+1];
  pos_t        ex_last  [MAX_EXCLUDED+1];
  int unsigned ex_cnt;

  lookup_res_t answer_q [$];
  lookup_res_t want;

  function automatic lookup_res_t classify_pos(pos_t pos, logic assessed, logic elig);
    lookup_res_t r;
    int unsigned lo, hi, mid;
    bit          excluded;
    r = '{bucket: BKT_UNASSESSED, size_class: '0};
    excluded = 1'b0;
    for (int k = 0; k < ex_cnt; k++) begin
      if (pos >= ex_first[k] && pos <= ex_last[k]) excluded = 1'b1;
    end
    if (!assessed) begin
      r.bucket = BKT_UNASSESSED;
    end else if (!elig) begin
      r.bucket = BKT_INELIGIBLE;
    end else if (pos < span_lo || pos > span_hi) begin
      r.bucket = BKT_UNASSESSED;
    end else if (gap_hi > gap_lo && pos >= gap_lo && pos <= gap_hi) begin
      r.bucket = BKT_UNASSESSED;
    end else if (excluded) begin
      r.bucket = BKT_UNASSESSED;
    end else begin
      // Find the last tract whose start is at or before the position.
      lo = 0;
      hi = tr_cnt;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (tr_first[mid] <= pos) lo = mid + 1;
        else hi = mid;
      end
      if (lo != 0 && pos <= tr_last[lo-1]) begin
        r.bucket     = BKT_TRACT;
        r.size_class = tr_cls[lo-1];
      end else begin
        r.bucket = BKT_NONE;
      end
    end
    return r;
  endfunction

  function automatic lookup_res_t lookup_answer(func_e func, pos_t first_pos, pos_t last_pos,
                                                cls_t lcls, logic assessed, logic elig);
    lookup_res_t r;
    r = '{bucket: BKT_LOADED, size_class: '0};
    case (func)
      FUNC_LOAD_TRACT: begin
        if (tr_cnt >= MAX_TRACTS) begin
          r.bucket = BKT_FULL;
        end else begin
          tr_first[tr_cnt] = first_pos;
          tr_last[tr_cnt]  = last_pos;
          tr_cls[tr_cnt]   = (int'(lcls) >= NUM_CLASSES) ? cls_t'(NUM_CLASSES - 1) : lcls;
          tr_cnt++;
        end
      end
      FUNC_LOAD_SKIP: begin
        if (ex_cnt >= MAX_EXCLUDED) begin
          r.bucket = BKT_FULL;
        end else begin
          ex_first[ex_cnt] = first_pos;
          ex_last[ex_cnt]  = last_pos;
          ex_cnt++;
        end
      end
      FUNC_QUERY: begin
        r = classify_pos(first_pos, assessed, elig);
      end
      default: begin
        tr_cnt = 0;
        ex_cnt = 0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_lo   = '0;
      span_hi   = '1;
      gap_lo    = '0;
      gap_hi    = '0;
      tr_cnt    = 0;
      ex_cnt    = 0;
      answer_q.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
      hits_o    = 0;
    end else begin
      // A result taken in the same cycle as a new item belongs to an older item.
      if (rsp_i.valid && rsp_i.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with nothing expected, bucket %0d class %0d", $time,
                   rsp_i.bucket, rsp_i.size_class);
          errors_o++;
        end else begin
          want = answer_q.pop_front();
          if (rsp_i.bucket !== want.bucket) begin
            $display("%0t: bucket mismatch, expected %0d got %0d", $time, want.bucket,
                     rsp_i.bucket);
            errors_o++;
          end
          if (rsp_i.size_class !== want.size_class) begin
            $display("%0t: size_class mismatch, expected %0d got %0d", $time,
                     want.size_class, rsp_i.size_class);
            errors_o++;
          end
          checked_o++;
          if (want.bucket == BKT_TRACT) hits_o++;
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CFG_SPAN_LOW:  span_lo = cfg_i.data;
          CFG_SPAN_HIGH: span_hi = cfg_i.data;
          CFG_GAP_LOW:   gap_lo  = cfg_i.data;
          CFG_GAP_HIGH:  gap_hi  = cfg_i.data;
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        answer_q = {answer_q, lookup_answer(req_i.func, req_i.first_pos, req_i.last_pos,
                                            req_i.load_class, req_i.chr_assessed,
                                            req_i.eligible)};
      end
      pending_o = answer_q.size();
    end
  end

endmodule

### test/tb_interval_tract_class_lookup_top.sv
// Testbench top for the interval tract class lookup: stimulus, idling and the verdict.
`timescale 1ns / 100ps
module tb_interval_tract_class_lookup_top;
  import itcl_pkg::*;

  localparam int unsigned ITEM_GOAL = 900;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_e;

  logic clk;
  logic rst_n;

  itcl_req_if req_if ();
  itcl_rsp_if rsp_if ();
  itcl_cfg_if cfg_if ();

  int unsigned errors, pending, checked, hits;
  int unsigned sent, n_queries, n_settings, burst_left;
  bit          gaps_on;
  pos_t        starts [$];
  pos_t        stops  [$];

  interval_tract_class_lookup_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  itcl_lookup_checker i_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .cfg_i     (cfg_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked),
    .hits_o    (hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run stopped by the time limit with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver switches at random between stall patterns: always ready, random and periodic.
  initial begin : rsp_stall
    stall_e      mode;
    int unsigned left;
    rsp_if.ready = 1'b0;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_e'($urandom_range(0, 2));
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        STALL_NONE:   rsp_if.ready = 1'b1;
        STALL_RANDOM: rsp_if.ready = 1'($urandom_range(0, 1));
        default:      rsp_if.ready = (left % 7) >= 3;
      endcase
    end
  end

  task automatic idle_req(int unsigned n);
    @(negedge clk);
    req_if.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_req(func_e f, pos_t first_pos, pos_t last_pos, cls_t cls,
                          logic assessed, logic elig);
    if (burst_left == 0) begin
      if (gaps_on && $urandom_range(0, 3) != 0) idle_req($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    req_if.valid        = 1'b1;
    req_if.func         = f;
    req_if.first_pos    = first_pos;
    req_if.last_pos     = last_pos;
    req_if.load_class   = cls;
    req_if.chr_assessed = assessed;
    req_if.eligible     = elig;
    do @(posedge clk); while (!req_if.ready);
    sent++;
  endtask

  // Fields that an operation does not use carry random values.
  task automatic load_tract(pos_t first_pos, pos_t last_pos, cls_t cls);
    send_req(FUNC_LOAD_TRACT, first_pos, last_pos, cls, 1'($urandom), 1'($urandom));
  endtask

  task automatic load_skip(pos_t first_pos, pos_t last_pos);
    send_req(FUNC_LOAD_SKIP, first_pos, last_pos, cls_t'($urandom), 1'($urandom),
             1'($urandom));
  endtask

  task automatic query(pos_t pos, logic assessed, logic elig);
    send_req(FUNC_QUERY, pos, $urandom, cls_t'($urandom), assessed, elig);
    n_queries++;
  endtask

  task automatic clear_tables();
    send_req(FUNC_CLEAR, $urandom, $urandom, cls_t'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic drain();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, pos_t data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.idx   = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_regs(pos_t s_lo, pos_t s_hi, pos_t g_lo, pos_t g_hi);
    drain();
    write_reg(CFG_SPAN_LOW, s_lo);
    write_reg(CFG_SPAN_HIGH, s_hi);
    write_reg(CFG_GAP_LOW, g_lo);
    write_reg(CFG_GAP_HIGH, g_hi);
    n_settings++;
  endtask

  // One phase: new register setting, mostly sorted tracts over a window, excluded intervals
  // (few, or at times a full list), then queries aimed mostly at the window and the tract edges.
  task automatic run_phase(int unsigned n_tr, bit force_clear);
    int unsigned       n_skip, n_query, sel, k;
    longint unsigned   base, cur, len, width, a;
    pos_t              pos;
    width = 64 * longint'(n_tr) + 1000;
    sel = $urandom_range(0, 3);
    if (sel == 0) base = 0;
    else if (sel == 1) base = 64'h0000_0000_FFFF_FFFF - width;
    else base = 64'($urandom_range(0, 32'(64'h0000_0000_FFFF_FFFF - width)));
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      a = base + 64'($urandom_range(0, 32'(width)));
      set_regs('0, '1, pos_t'(a), pos_t'(a + 64'($urandom_range(0, 200))));
    end else if (sel < 6) begin
      set_regs(pos_t'(base + width / 4), pos_t'(base + 3 * width / 4), '0, '0);
    end else if (sel == 6) begin
      set_regs('1, '0, '0, '0);
    end else if (sel == 7) begin
      set_regs('0, '1, '0, '1);
    end else if (sel == 8) begin
      set_regs($urandom, $urandom, $urandom, $urandom);
    end else begin
      set_regs('0, '1, '1, '0);
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    if (force_clear || $urandom_range(0, 9) != 0) clear_tables();
    starts.delete();
    stops.delete();
    cur = base + 64'($urandom_range(0, 20));
    for (int i = 0; i < n_tr; i++) begin
      len = 64'($urandom_range(0, 30));
      if ($urandom_range(0, 19) == 0) begin
        load_tract($urandom, $urandom, cls_t'($urandom));
      end else begin
        starts = {starts, pos_t'(cur)};
        // An occasional tract with its stop before its start.
        if ($urandom_range(0, 15) == 0) stops = {stops, pos_t'(cur - 1)};
        else stops = {stops, pos_t'(cur + len)};
        load_tract(starts[$], stops[$], cls_t'($urandom));
        cur = cur + len + 64'($urandom_range(0, 30));
      end
    end
    if ($urandom_range(0, 9) == 0) n_skip = $urandom_range(MAX_EXCLUDED_DEF, MAX_EXCLUDED_DEF + 2);
    else n_skip = $urandom_range(0, 3);
    for (int i = 0; i < n_skip; i++) begin
      a = base + 64'($urandom_range(0, 32'(width)));
      if ($urandom_range(0, 9) == 0) load_skip(pos_t'(a), pos_t'(a - 1));
      else load_skip(pos_t'(a), pos_t'(a + 64'($urandom_range(0, 10))));
    end
    n_query = $urandom_range(10, 40);
    for (int i = 0; i < n_query; i++) begin
      sel = $urandom_range(0, 9);
      if (starts.size() > 0 && sel < 4) begin
        k = $urandom_range(0, starts.size() - 1);
        case ($urandom_range(0, 3))
          0:       pos = starts[k] - 1;
          1:       pos = starts[k];
          2:       pos = stops[k];
          default: pos = stops[k] + 1;
        endcase
      end else if (sel < 8) begin
        pos = pos_t'(base + 64'($urandom_range(0, 32'(width))));
      end else begin
        pos = $urandom;
      end
      query(pos, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0);
      if ($urandom_range(0, 29) == 0) drain();
      if ($urandom_range(0, 24) == 0) begin
        len = 64'($urandom_range(0, 30));
        starts = {starts, pos_t'(cur)};
        stops = {stops, pos_t'(cur + len)};
        load_tract(starts[$], stops[$], cls_t'($urandom));
        cur = cur + len + 1;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned waited;
    bit          full_done;
    req_if.valid        = 1'b0;
    req_if.func         = FUNC_QUERY;
    req_if.first_pos    = '0;
    req_if.last_pos     = '0;
    req_if.load_class   = '0;
    req_if.chr_assessed = 1'b0;
    req_if.eligible     = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.idx          = CFG_SPAN_LOW;
    cfg_if.data         = '0;
    sent       = 0;
    n_queries  = 0;
    n_settings = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    full_done  = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset register values.
    query('0, 1'b1, 1'b1);
    query('1, 1'b0, 1'b1);
    query(32'd5, 1'b1, 1'b0);
    query(32'd5, 1'b0, 1'b0);
    load_tract(32'd100, 32'd200, 4'hF);
    load_tract(32'd300, 32'd250, 4'h0);
    load_tract(32'hFFFF_FF00, 32'hFFFF_FFFF, 4'h7);
    load_skip(32'd150, 32'd160);
    load_skip(32'd500, 32'd400);
    query(32'd99, 1'b1, 1'b1);
    query(32'd100, 1'b1, 1'b1);
    query(32'd155, 1'b1, 1'b1);
    query(32'd200, 1'b1, 1'b1);
    query(32'd201, 1'b1, 1'b1);
    query(32'd300, 1'b1, 1'b1);
    query(32'd450, 1'b1, 1'b1);
    query(32'hFFFF_FFFF, 1'b1, 1'b1);
    clear_tables();
    query(32'd100, 1'b1, 1'b1);
    // Span and gap limits, both edges of each.
    set_regs(32'd1000, 32'd5000, 32'd2000, 32'd3000);
    load_tract(32'd0, 32'hFFFF_FFFF, 4'h3);
    query(32'd999, 1'b1, 1'b1);
    query(32'd1000, 1'b1, 1'b1);
    query(32'd2000, 1'b1, 1'b1);
    query(32'd3001, 1'b1, 1'b1);
    query(32'd5001, 1'b1, 1'b1);
    // A gap whose ends are equal does not apply.
    set_regs('0, '1, 32'd4000, 32'd4000);
    query(32'd4000, 1'b1, 1'b1);

    // Filling the tract table past its capacity takes most of the item budget.
    while (sent < ITEM_GOAL) begin
      if (!full_done && sent >= ITEM_GOAL / 8) begin
        full_done = 1'b1;
        run_phase(MAX_TRACTS_DEF + 2, 1'b1);
      end else begin
        run_phase($urandom_range(0, 40), 1'b0);
      end
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("Timed out with %0d results still expected", pending);
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (40) @(negedge clk);
      $display("Sent %0d items (%0d queries) over %0d register settings;", sent, n_queries,
               n_settings);
      $display("checked %0d results, %0d of them inside a tract.", checked, hits);
      if (errors == 0 && pending == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule

### interval_tract_class_lookup_top.f
rtl/itcl_pkg.sv
rtl/itcl_if.sv
rtl/interval_tract_class_lookup_top.sv
test/itcl_lookup_checker.sv
test/tb_interval_tract_class_lookup_top.sv
